>>> rtl/core/pasn_pkg.sv
package pasn_pkg;

  localparam logic [3:0] KIND_PUSH      = 4'd0;
  localparam logic [3:0] KIND_POP       = 4'd1;
  localparam logic [3:0] KIND_GET       = 4'd2;
  localparam logic [3:0] KIND_SET       = 4'd3;
  localparam logic [3:0] KIND_SET_RESET = 4'd4;
  localparam logic [3:0] KIND_CLEAR     = 4'd5;
  localparam logic [3:0] KIND_CLEAR_ALL = 4'd6;
  localparam logic [3:0] KIND_NEST_PUSH = 4'd7;
  localparam logic [3:0] KIND_NEST_POP  = 4'd8;

  localparam logic [1:0] SIZE_BIT   = 2'd0;
  localparam logic [1:0] SIZE_BYTE  = 2'd1;
  localparam logic [1:0] SIZE_WORD  = 2'd2;
  localparam logic [1:0] SIZE_DWORD = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] load_value;
    logic [1:0]         data_size;
    logic [15:0]        sel_bits;
    logic [15:0]        bit_values;
    logic [7:0]         nest_command;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic               value_written;
    logic [15:0]        status_bits;
    logic [7:0]         popped_command;
    logic               popped_rlo;
    logic               popped_or;
    logic [1:0]         error_code;
  } out_word_t;

  typedef struct packed {
    logic exec;
    logic load_imm;
    logic load_mem;
  } dp_cmd_t;

  typedef struct packed {
    logic need_read;
  } dp_sts_t;

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    logic [31:0] m;
    case (sz)
      SIZE_BYTE:  m = 32'h0000_00FF;
      SIZE_WORD:  m = 32'h0000_FFFF;
      SIZE_DWORD: m = 32'hFFFF_FFFF;
      default:    m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/pasn_ctrl.sv
module pasn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pasn_pkg::dp_sts_t sts,
  output pasn_pkg::dp_cmd_t cmd
);
  import pasn_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.exec     = accept;
    cmd.load_imm = accept && !sts.need_read;
    cmd.load_mem = (state_r == S_READ);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept && sts.need_read) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cmd.load_imm || cmd.load_mem) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && sts.need_read) |=> (state_r == S_READ) && !out_valid_r)
    else $error("nesting pop read did not start correctly");

  a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> out_valid_r)
    else $error("nesting pop read produced no result word");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(state_r == S_IDLE))
    else $error("stalled result word was dropped");
`endif

endmodule

>>> rtl/core/pasn_dpath.sv
module pasn_dpath #(
  parameter int NEST_DEPTH = 8,
  parameter int RLO_BIT    = 1,
  parameter int OR_BIT     = 3,
  parameter int NOT_FC_BIT = 0
) (
  input  logic                clk,
  input  pasn_pkg::in_word_t  in_word,
  input  pasn_pkg::dp_cmd_t   cmd,
  output pasn_pkg::dp_sts_t   sts,
  output pasn_pkg::out_word_t out_word,
  input  logic                rst_n
);
  import pasn_pkg::*;

  localparam int CW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  logic [31:0]   acc_r [4];
  logic [15:0]   status_r;
  logic [15:0]   status_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [9:0]    nest_mem [NEST_DEPTH];
  logic [9:0]    rd_data_r;
  out_word_t     out_word_r;
  out_word_t     imm_word;
  out_word_t     mem_word;
  logic          push_ok;
  logic          pop_ok;
  logic          saved_rlo;
  logic [31:0]   masked_load;

  assign push_ok = (in_word.kind == KIND_NEST_PUSH) && (count_r < CW'(NEST_DEPTH - 1));
  assign pop_ok  = (in_word.kind == KIND_NEST_POP) && (count_r != '0);
  assign sts.need_read = pop_ok;
  assign saved_rlo = status_r[NOT_FC_BIT] ? status_r[RLO_BIT] : 1'b1;
  assign masked_load = 32'(in_word.load_value) & size_mask(in_word.data_size);

  always_comb begin
    imm_word   = '0;
    status_nxt = status_r;
    count_nxt  = count_r;
    case (in_word.kind)
      KIND_POP: begin
        imm_word.pop_value     = signed'(acc_r[0] & size_mask(in_word.data_size));
        imm_word.value_written = (in_word.data_size != SIZE_BIT);
      end
      KIND_GET: begin
        imm_word.status_bits = status_r & in_word.sel_bits;
      end
      KIND_SET: begin
        status_nxt = status_r | in_word.sel_bits;
      end
      KIND_SET_RESET: begin
        status_nxt = (status_r & ~in_word.sel_bits) | (in_word.sel_bits & in_word.bit_values);
      end
      KIND_CLEAR: begin
        status_nxt = status_r & ~in_word.sel_bits;
      end
      KIND_CLEAR_ALL: begin
        status_nxt = '0;
      end
      KIND_NEST_PUSH: begin
        if (push_ok) begin
          count_nxt = count_r + 1'b1;
        end else begin
          imm_word.error_code = ERR_OVERFLOW;
        end
      end
      KIND_NEST_POP: begin
        if (pop_ok) begin
          count_nxt = count_r - 1'b1;
        end else begin
          imm_word.error_code = ERR_UNDERFLOW;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_word                = '0;
    mem_word.popped_command = rd_data_r[7:0];
    mem_word.popped_rlo     = rd_data_r[8];
    mem_word.popped_or      = rd_data_r[9];
    mem_word.error_code     = ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
      count_r  <= '0;
    end else if (cmd.exec) begin
      status_r <= status_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (in_word.kind == KIND_PUSH) begin
        acc_r[3] <= acc_r[2];
        acc_r[2] <= acc_r[1];
        acc_r[1] <= acc_r[0];
        acc_r[0] <= masked_load;
      end else if (in_word.kind == KIND_POP) begin
        acc_r[0] <= acc_r[1];
        acc_r[1] <= acc_r[2];
        acc_r[2] <= acc_r[3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      nest_mem[count_r] <= {status_r[OR_BIT], saved_rlo, in_word.nest_command};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && pop_ok) begin
      rd_data_r <= nest_mem[count_r - 1'b1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_imm) begin
      out_word_r <= imm_word;
    end else if (cmd.load_mem) begin
      out_word_r <= mem_word;
    end
  end

  assign out_word = out_word_r;

endmodule

>>> rtl/core/plc_accu_status_nesting_unit.sv
// PLC accumulator, status word and bracket nesting unit.
// Input channel in_valid/in_stall/in_word carries one operation word: an
// accumulator push or pop, a status word access, or a bracket nesting push
// or pop. Result channel out_valid/out_stall/out_word returns exactly one
// result word for every accepted operation, in order.
// The result word is registered on acceptance for all operations but a
// nesting pop on a non-empty stack, which first reads the nesting stack,
// a memory with a registered read port, and loads the result in S_READ.
// Throughput is one word per cycle while out_stall is low; a nesting pop
// with data holds in_stall high in S_READ while the stack memory is read.
// The result sits in an output register, so a new word is accepted in the
// same cycle the previous result is taken.
// While out_stall is high and a result is waiting, in_stall is raised and
// the result word is held unchanged.
// Synchronous reset clears the status word, the nesting depth and the
// handshake state. Accumulators and stack entries are not cleared and
// must be written before they are read.
module plc_accu_status_nesting_unit #(
  parameter int NEST_DEPTH = 8,
  parameter int RLO_BIT    = 1,
  parameter int OR_BIT     = 3,
  parameter int NOT_FC_BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pasn_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output pasn_pkg::out_word_t out_word
);
  import pasn_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pasn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pasn_dpath #(
    .NEST_DEPTH (NEST_DEPTH),
    .RLO_BIT    (RLO_BIT),
    .OR_BIT     (OR_BIT),
    .NOT_FC_BIT (NOT_FC_BIT)
  ) u_dpath (
    .clk      (clk),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word),
    .rst_n    (rst_n)
  );

endmodule
